// File: rtl/core/rat_pkg.sv
// Shared types, opcodes and helpers for the rational accumulator.
`timescale 1ns / 1ps

package rat_pkg;

    localparam int DATA_W = 32;
    localparam int SHIFT_W = 5;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SCALE  = 3'd2;
    localparam logic [2:0] OP_SETDEN = 3'd3;
    localparam logic [2:0] OP_REDUCE = 3'd4;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] operand_numerator;
        logic signed [DATA_W-1:0] operand_denominator;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_numerator;
        logic signed [DATA_W-1:0] result_denominator;
        logic                     zero_denominator_error;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DEN,
        ST_MUL_AD,
        ST_MUL_NB,
        ST_ADD_SUM,
        ST_MUL_SCALE,
        ST_SCALE_WB,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_DONE
    } t_state;

    // Two's complement magnitude; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// File: rtl/core/rat_mul.sv
// Shared multiplier with a registered low-half product.
`timescale 1ns / 1ps

module rat_mul (
    input  logic                        i_clk,
    input  logic [rat_pkg::DATA_W-1:0]  i_a,
    input  logic [rat_pkg::DATA_W-1:0]  i_b,
    output logic [rat_pkg::DATA_W-1:0]  o_prod
);
    import rat_pkg::*;

    logic [2*DATA_W-1:0] full_prod;
    logic [DATA_W-1:0]   r_prod;

    assign full_prod = i_a * i_b;

    // The low half is the same for signed and unsigned operands.
    always_ff @(posedge i_clk) begin
        r_prod <= full_prod[DATA_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/rat_gcd.sv
// Binary greatest common divisor, one shift or subtract step per cycle.
`timescale 1ns / 1ps

module rat_gcd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rat_pkg::DATA_W-1:0]  i_u,
    input  logic [rat_pkg::DATA_W-1:0]  i_v,
    output logic                        o_done,
    output logic [rat_pkg::DATA_W-1:0]  o_gcd
);
    import rat_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DATA_W-1:0]  r_u;
    logic [DATA_W-1:0]  r_v;
    logic [SHIFT_W-1:0] r_k;
    logic [DATA_W-1:0]  r_g;

    logic               u_ge_v;
    logic [DATA_W-1:0]  diff;
    logic               finish;
    logic [DATA_W-1:0]  fin_val;

    assign u_ge_v  = (r_u >= r_v);
    assign diff    = u_ge_v ? (r_u - r_v) : (r_v - r_u);
    assign finish  = (r_u == '0) || (r_v == '0);
    assign fin_val = ((r_u == '0) ? r_v : r_u) << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && finish) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Common factors of two are counted in r_k and restored at the end.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u <= i_u;
            r_v <= i_v;
            r_k <= '0;
        end else if (r_busy) begin
            if (finish) begin
                r_g <= fin_val;
            end else if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (u_ge_v) begin
                r_u <= diff >> 1;
            end else begin
                r_v <= diff >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;

endmodule

// File: rtl/core/rat_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rat_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rat_pkg::DATA_W-1:0]  i_dividend,
    input  logic [rat_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [rat_pkg::DATA_W-1:0]  o_quot
);
    import rat_pkg::*;

    localparam logic [SHIFT_W-1:0] LAST_STEP = SHIFT_W'(DATA_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [SHIFT_W-1:0] r_cnt;
    logic [DATA_W-1:0]  r_rem;
    logic [DATA_W-1:0]  r_quot;
    logic [DATA_W-1:0]  r_dvs;

    logic [DATA_W:0]    rem_sh;
    logic               fits;
    logic [DATA_W:0]    rem_next;

    assign rem_sh   = {r_rem, r_quot[DATA_W-1]};
    assign fits     = (rem_sh >= {1'b0, r_dvs});
    assign rem_next = fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of r_quot as the quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= rem_next[DATA_W-1:0];
            r_quot <= {r_quot[DATA_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/core/rational_accumulator.sv
// Rational accumulator: holds one fraction and applies one opcode per input beat.
//
// Input channel: i_in_valid, o_in_stall, i_in_data. A beat is taken when valid is
// high and stall is low. The block works on one item at a time and raises
// o_in_stall from acceptance until its result is in the output register.
// Output channel: o_out_valid, i_out_stall, o_out_data; one result beat per item,
// holding the fraction after the operation and the zero-denominator flag.
// Load, set denominator and unused opcodes go straight to the done state; scale
// passes through its multiply and write-back states, add through the states for
// the denominator product, the two cross products and the sum. o_in_stall falls
// as o_out_valid rises, so the next beat can be taken while the result is held.
// Reduce runs a binary GCD at one step per cycle and then two 32-bit restoring
// divisions on the shared divider, numerator then denominator by the GCD; the
// divisions are skipped when the GCD is zero.
// While the receiver stalls, the result beat holds; a new item may be taken
// meanwhile and runs until its own result is ready, then waits for the register.
// Reset (synchronous, active low) sets the fraction to 0/1 and empties the
// output register.
`timescale 1ns / 1ps

module rational_accumulator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rat_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rat_pkg::t_out_item  o_out_data
);
    import rat_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_in_item          r_item;
    logic [DATA_W-1:0] r_num;
    logic [DATA_W-1:0] n_num;
    logic [DATA_W-1:0] r_den;
    logic [DATA_W-1:0] n_den;
    logic [DATA_W-1:0] r_nd;
    logic [DATA_W-1:0] n_nd;
    logic [DATA_W-1:0] r_p1;
    logic [DATA_W-1:0] n_p1;
    logic [DATA_W-1:0] r_g;
    logic [DATA_W-1:0] n_g;
    logic              r_err;
    logic              n_err;
    logic              r_ov;
    logic              n_ov;
    t_out_item         r_out;

    logic              in_acc;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] mul_prod;
    logic              gcd_start;
    logic              gcd_done;
    logic [DATA_W-1:0] gcd_val;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_dividend;
    logic [DATA_W-1:0] div_divisor;
    logic [DATA_W-1:0] div_quot;
    logic              out_load;

    assign in_acc = i_in_valid && (r_state == ST_IDLE);

    rat_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    rat_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_u     (magnitude(r_num)),
        .i_v     (magnitude(r_den)),
        .o_done  (gcd_done),
        .o_gcd   (gcd_val)
    );

    rat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.opcode)
                        OP_ADD:    n_state = ST_MUL_DEN;
                        OP_SCALE:  n_state = ST_MUL_SCALE;
                        OP_REDUCE: n_state = ST_GCD;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_MUL_DEN:   n_state = ST_MUL_AD;
            ST_MUL_AD:    n_state = ST_MUL_NB;
            ST_MUL_NB:    n_state = ST_ADD_SUM;
            ST_ADD_SUM:   n_state = ST_DONE;
            ST_MUL_SCALE: n_state = ST_SCALE_WB;
            ST_SCALE_WB:  n_state = ST_DONE;
            ST_GCD: begin
                if (gcd_done) begin
                    n_state = (gcd_val == '0) ? ST_DONE : ST_DIV_NUM;
                end
            end
            ST_DIV_NUM: begin
                if (div_done) begin
                    n_state = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: operand selection and unit starts.
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        gcd_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        out_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                gcd_start = in_acc && (i_in_data.opcode == OP_REDUCE);
            end
            ST_MUL_DEN: begin
                mul_a = r_item.operand_denominator;
                mul_b = r_den;
            end
            ST_MUL_AD: begin
                mul_a = r_item.operand_numerator;
                mul_b = r_den;
            end
            ST_MUL_NB: begin
                mul_a = r_num;
                mul_b = r_item.operand_denominator;
            end
            ST_MUL_SCALE: begin
                mul_a = r_num;
                mul_b = r_item.operand_numerator;
            end
            ST_GCD: begin
                if (gcd_done && (gcd_val != '0)) begin
                    div_start    = 1'b1;
                    div_dividend = magnitude(r_num);
                end
            end
            ST_DIV_NUM: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = magnitude(r_den);
                end
            end
            ST_DONE: begin
                out_load = !r_ov || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    assign div_divisor = (r_state == ST_GCD) ? gcd_val : r_g;

    // Fraction and scratch register updates.
    always_comb begin
        n_num = r_num;
        n_den = r_den;
        n_nd  = r_nd;
        n_p1  = r_p1;
        n_g   = r_g;
        n_err = r_err;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_err = 1'b0;
                    case (i_in_data.opcode)
                        OP_LOAD: begin
                            if (i_in_data.operand_denominator == '0) begin
                                n_err = 1'b1;
                            end else begin
                                n_num = i_in_data.operand_numerator;
                                n_den = i_in_data.operand_denominator;
                            end
                        end
                        OP_SETDEN: begin
                            if (i_in_data.operand_denominator == '0) begin
                                n_err = 1'b1;
                            end else begin
                                n_den = i_in_data.operand_denominator;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL_AD: n_nd = mul_prod;
            ST_MUL_NB: n_p1 = mul_prod;
            ST_ADD_SUM: begin
                // A wrapped product denominator of zero is refused as well.
                if ((r_item.operand_denominator == '0) || (r_nd == '0)) begin
                    n_err = 1'b1;
                end else begin
                    n_num = r_p1 + mul_prod;
                    n_den = r_nd;
                end
            end
            ST_SCALE_WB: n_num = mul_prod;
            ST_GCD: begin
                if (gcd_done) begin
                    n_g = gcd_val;
                end
            end
            ST_DIV_NUM: begin
                if (div_done) begin
                    n_num = r_num[DATA_W-1] ? (~div_quot + 1'b1) : div_quot;
                end
            end
            ST_DIV_DEN: begin
                if (div_done) begin
                    n_den = r_den[DATA_W-1] ? (~div_quot + 1'b1) : div_quot;
                end
            end
            default: begin
            end
        endcase
    end

    assign n_ov = out_load || (r_ov && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_num   <= '0;
            r_den   <= DATA_W'(1);
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_num   <= n_num;
            r_den   <= n_den;
            r_err   <= n_err;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nd <= n_nd;
        r_p1 <= n_p1;
        r_g  <= n_g;
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (out_load) begin
            r_out.result_numerator       <= r_num;
            r_out.result_denominator     <= r_den;
            r_out.zero_denominator_error <= r_err;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // The held denominator is never allowed to become zero.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_den != '0)
        else $error("held denominator became zero");

    a_gcd_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gcd_done |-> r_state == ST_GCD)
        else $error("GCD finished outside its sequencer step");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV_NUM || r_state == ST_DIV_DEN))
        else $error("divider finished outside a division step");

    // A stalled result beat must not be overwritten by a finishing item.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall && r_state == ST_DONE) |=> r_state == ST_DONE)
        else $error("result register overwritten while stalled");

endmodule

// File: verif/rational_accumulator_tb.sv
// Self-checking testbench for the rational accumulator: directed and random operations.
`timescale 1ns / 1ps

import rat_pkg::*;

class fraction_scoreboard;
    logic [DATA_W-1:0] frac_num;
    logic [DATA_W-1:0] frac_den;
    t_out_item         pending[$];
    int unsigned       fault_count;

    function new();
        frac_num    = '0;
        frac_den    = 32'd1;
        fault_count = 0;
    endfunction

    static function logic [DATA_W-1:0] abs_u32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (32'd0 - v) : v;
    endfunction

    // Quotient of a signed value by a positive divisor, keeping the sign of the value.
    static function logic [DATA_W-1:0] signed_quot(input logic [DATA_W-1:0] v,
                                                   input logic [DATA_W-1:0] g);
        logic [DATA_W-1:0] q;
        q = abs_u32(v) / g;
        return v[DATA_W-1] ? (32'd0 - q) : q;
    endfunction

    function void note_input(input t_in_item item);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] den_prod;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] r;
        logic              refused;
        t_out_item         exp_item;
        a       = item.operand_numerator;
        b       = item.operand_denominator;
        refused = 1'b0;
        case (item.opcode)
            OP_LOAD: begin
                if (b == 0) begin
                    refused = 1'b1;
                end else begin
                    frac_num = a;
                    frac_den = b;
                end
            end
            OP_ADD: begin
                den_prod = b * frac_den;
                if (b == 0 || den_prod == 0) begin
                    refused = 1'b1;
                end else begin
                    frac_num = a * frac_den + frac_num * b;
                    frac_den = den_prod;
                end
            end
            OP_SCALE: begin
                frac_num = frac_num * a;
            end
            OP_SETDEN: begin
                if (b == 0) begin
                    refused = 1'b1;
                end else begin
                    frac_den = b;
                end
            end
            OP_REDUCE: begin
                x = abs_u32(frac_num);
                y = abs_u32(frac_den);
                while (y != 0) begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                if (x != 0) begin
                    frac_num = signed_quot(frac_num, x);
                    frac_den = signed_quot(frac_den, x);
                end
            end
            default: begin
            end
        endcase
        exp_item.result_numerator       = frac_num;
        exp_item.result_denominator     = frac_den;
        exp_item.zero_denominator_error = refused;
        pending.push_back(exp_item);
    endfunction

    function void check_result(input t_out_item got);
        t_out_item exp_item;
        if (pending.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
                $display("unexpected result beat: %0d/%0d err %0b",
                         got.result_numerator, got.result_denominator,
                         got.zero_denominator_error);
            return;
        end
        exp_item = pending.pop_front();
        if (got.result_numerator !== exp_item.result_numerator ||
                got.result_denominator !== exp_item.result_denominator ||
                got.zero_denominator_error !== exp_item.zero_denominator_error) begin
            fault_count++;
            if (fault_count <= 10)
                $display("mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
                         exp_item.result_numerator, exp_item.result_denominator,
                         exp_item.zero_denominator_error, got.result_numerator,
                         got.result_denominator, got.zero_denominator_error);
        end
    endfunction
endclass

module rational_accumulator_tb;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS = 175;
    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    fraction_scoreboard frac_sb;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    int unsigned        quiet_cycles;

    rational_accumulator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Results are checked on the values seen before the edge; stall is redrawn every cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            frac_sb.check_result(o_out_data);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    // Holds the beat until it is taken; the payload stays put while stalled.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        frac_sb.note_input(item);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b);
        t_in_item item;
        item.opcode              = op;
        item.operand_numerator   = a;
        item.operand_denominator = b;
        send_item(item);
    endtask

    function automatic logic [DATA_W-1:0] pick_operand();
        int unsigned       sel;
        logic [DATA_W-1:0] v;
        sel = $urandom_range(99);
        if (sel < 40) begin
            v = $urandom_range(128);
            v = v - 32'd64;
        end else if (sel < 70) begin
            v = $urandom;
        end else if (sel < 80) begin
            case ($urandom_range(4))
                0: v = '0;
                1: v = 32'd1;
                2: v = '1;
                3: v = MOST_POS;
                default: v = MOST_NEG;
            endcase
        end else begin
            // Small factors times a power of two give large common divisors and
            // denominator products that wrap to zero.
            v = $urandom_range(16, 1);
            v = v << $urandom_range(31);
            if ($urandom_range(1) != 0)
                v = 32'd0 - v;
        end
        return v;
    endfunction

    function automatic logic [2:0] pick_opcode();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 22)
            return OP_LOAD;
        else if (sel < 40)
            return OP_ADD;
        else if (sel < 55)
            return OP_SCALE;
        else if (sel < 68)
            return OP_SETDEN;
        else if (sel < 94)
            return OP_REDUCE;
        return 3'($urandom_range(7, 5));
    endfunction

    // Mostly a load, a few operations and a closing reduce; now and then either end is left off.
    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        t_in_item    item;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(5, 1);
            for (int j = 0; j <= len + 1 && sent < n_items; j++) begin
                if (j == 0 && $urandom_range(9) != 0)
                    item.opcode = OP_LOAD;
                else if (j == len + 1 && $urandom_range(9) != 0)
                    item.opcode = OP_REDUCE;
                else
                    item.opcode = pick_opcode();
                item.operand_numerator   = pick_operand();
                item.operand_denominator = pick_operand();
                send_item(item);
                sent++;
            end
        end
    endtask

    initial begin
        frac_sb        = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(OP_REDUCE, 0, 0);
        send_op(OP_LOAD, 6, -4);
        send_op(OP_REDUCE, 0, 0);
        send_op(OP_LOAD, 5, 0);
        send_op(OP_SETDEN, 0, 0);
        send_op(OP_ADD, 1, 0);
        send_op(OP_ADD, 1, 3);
        // A denominator product of 2^32 wraps to zero and must be refused.
        send_op(OP_SETDEN, 0, 65536);
        send_op(OP_ADD, 1, 65536);
        send_op(OP_SCALE, -1, 0);
        send_op(OP_SCALE, MOST_POS, 0);
        send_op(OP_SCALE, 0, 0);
        send_op(OP_REDUCE, 0, 0);
        send_op(OP_LOAD, MOST_NEG, MOST_NEG);
        send_op(OP_REDUCE, 0, 0);
        send_op(OP_LOAD, MOST_POS, MOST_NEG);
        send_op(OP_LOAD, MOST_NEG, MOST_POS);
        send_op(OP_REDUCE, 0, 0);
        send_op(OP_SETDEN, MOST_POS, MOST_NEG);
        send_op(3'd5, '1, '1);
        send_op(3'd6, MOST_NEG, MOST_POS);
        send_op(3'd7, 0, 0);
        send_op(OP_LOAD, 0, -8);
        send_op(OP_REDUCE, 0, 0);
        send_op(OP_LOAD, 48, 180);

        run_random(PHASE_ITEMS);
        send_idle_pct = 88;
        run_random(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        run_random(PHASE_ITEMS);
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        run_random(PHASE_ITEMS);
        i_in_valid <= 1'b0;

        while (frac_sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (frac_sb.fault_count == 0 && frac_sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: rational_accumulator.f
rtl/core/rat_pkg.sv
rtl/core/rat_mul.sv
rtl/core/rat_gcd.sv
rtl/core/rat_div.sv
rtl/core/rational_accumulator.sv
verif/rational_accumulator_tb.sv
